FILE: rtl/core/wsfpe_pkg.sv
// ----------------------------------------------------------------------------
// wsfpe_pkg
// shared constants, codes and control types of the ws2812 frame encoder
// ----------------------------------------------------------------------------
package wsfpe_pkg;

  // frame geometry
  localparam int LED_COUNT         = 64;
  localparam int LEAD_RESET_SLOTS  = 64;
  localparam int TRAIL_RESET_SLOTS = 64;
  localparam int BITS_PER_LED      = 24;
  localparam int DATA_SLOTS        = LED_COUNT * BITS_PER_LED;
  localparam int FRAME_SLOTS       = LEAD_RESET_SLOTS + DATA_SLOTS + 1 + TRAIL_RESET_SLOTS;
  localparam int SLOT_W            = $clog2(FRAME_SLOTS);
  localparam int LED_AW            = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BIT_W             = $clog2(BITS_PER_LED);

  // field widths
  localparam int CH_W    = 8;
  localparam int DUTY_W  = 10;
  localparam int IDX_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int WORD_W  = 3 * CH_W;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 10;

  // divider widths
  localparam int DIVD_W  = 2 * CH_W;
  localparam int DIVS_W  = CH_W + 1;

  // white mixing: x / 7 as (x * 2341) >> 14, exact for x up to 6 * 255
  localparam int MIX_NW    = 11;
  localparam int MIX_PW    = 23;
  localparam int MIX_RECIP = 2341;
  localparam int MIX_SHIFT = 14;

  // register reset values
  localparam logic [CH_W-1:0]   BRIGHT_RST = 8'd255;
  localparam logic [DUTY_W-1:0] ONE_RST    = 10'd60;
  localparam logic [DUTY_W-1:0] ZERO_RST   = 10'd30;
  localparam logic [DUTY_W-1:0] RESET_RST  = 10'd0;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_BRIGHT = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ONE    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ZERO   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_RESET  = 2'd3;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_SET_RGB  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_RGBW = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd3;

  // divider operations of a pixel write
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_SC_R  = 2'd0;
  localparam logic [OP_W-1:0] OP_SC_G  = 2'd1;
  localparam logic [OP_W-1:0] OP_SC_B  = 2'd2;

  typedef struct packed {
    logic            load;
    logic            clear;
    logic            mix;
    logic            div_start;
    logic            capture;
    logic [OP_W-1:0] op;
    logic            mem_wr;
    logic            mem_rd;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic m_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/wsfpe_div.sv
// ----------------------------------------------------------------------------
// wsfpe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsfpe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wsfpe_pkg::DIVD_W-1:0]  dividend,
  input  logic [wsfpe_pkg::DIVS_W-1:0]  divisor,
  output logic [wsfpe_pkg::DIVD_W-1:0]  quo,
  output logic                          busy,
  output logic                          done
);

  localparam int CNT_W = $clog2(wsfpe_pkg::DIVD_W);

  logic [wsfpe_pkg::DIVD_W-1:0] dvd_r;
  logic [wsfpe_pkg::DIVS_W-1:0] rem_r;
  logic [wsfpe_pkg::DIVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [wsfpe_pkg::DIVS_W:0]   trial;
  logic [wsfpe_pkg::DIVS_W:0]   diff;
  logic                         fits;

  assign trial = {rem_r, dvd_r[wsfpe_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(wsfpe_pkg::DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= diff[wsfpe_pkg::DIVS_W-1:0];
      end else begin
        rem_r <= trial[wsfpe_pkg::DIVS_W-1:0];
      end
      dvd_r <= {dvd_r[wsfpe_pkg::DIVD_W-2:0], fits};
    end
  end

  assign quo  = dvd_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

FILE: rtl/core/wsfpe_dp.sv
// ----------------------------------------------------------------------------
// wsfpe_dp
// datapath: registers, pixel memory, divider, slot counters, output register
// ----------------------------------------------------------------------------
module wsfpe_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wsfpe_pkg::cmd_t                cmd,
  output wsfpe_pkg::sts_t                sts,
  input  logic [wsfpe_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [wsfpe_pkg::CH_W-1:0]     in_red,
  input  logic [wsfpe_pkg::CH_W-1:0]     in_green,
  input  logic [wsfpe_pkg::CH_W-1:0]     in_blue,
  input  logic [wsfpe_pkg::CH_W-1:0]     in_white,
  input  logic                           cfg_we,
  input  logic [wsfpe_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [wsfpe_pkg::CFG_DW-1:0]   cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wsfpe_pkg::DUTY_W-1:0]   out_duty,
  output logic                           out_last
);

  localparam logic [wsfpe_pkg::SLOT_W-1:0] DATA_START =
    wsfpe_pkg::SLOT_W'(wsfpe_pkg::LEAD_RESET_SLOTS);
  localparam logic [wsfpe_pkg::SLOT_W-1:0] EXTRA_SLOT =
    wsfpe_pkg::SLOT_W'(wsfpe_pkg::LEAD_RESET_SLOTS + wsfpe_pkg::DATA_SLOTS);
  localparam logic [wsfpe_pkg::SLOT_W-1:0] LAST_SLOT =
    wsfpe_pkg::SLOT_W'(wsfpe_pkg::FRAME_SLOTS - 1);
  localparam logic [wsfpe_pkg::BIT_W-1:0] MSB_BIT =
    wsfpe_pkg::BIT_W'(wsfpe_pkg::BITS_PER_LED - 1);
  localparam logic [wsfpe_pkg::LED_AW-1:0] LAST_LED =
    wsfpe_pkg::LED_AW'(wsfpe_pkg::LED_COUNT - 1);

  // configuration
  logic [wsfpe_pkg::CH_W-1:0]   bright_r;
  logic [wsfpe_pkg::DUTY_W-1:0] one_r;
  logic [wsfpe_pkg::DUTY_W-1:0] zero_r;
  logic [wsfpe_pkg::DUTY_W-1:0] rst_duty_r;

  // pixel write operands
  logic [wsfpe_pkg::LED_AW-1:0] addr_r;
  logic [wsfpe_pkg::CH_W-1:0]   red_r;
  logic [wsfpe_pkg::CH_W-1:0]   green_r;
  logic [wsfpe_pkg::CH_W-1:0]   blue_r;
  logic [wsfpe_pkg::CH_W-1:0]   white_r;
  logic [wsfpe_pkg::WORD_W-1:0] word_r;
  logic [wsfpe_pkg::CH_W-1:0]   max_c;
  logic [wsfpe_pkg::CH_W-1:0]   sel_c;
  logic [wsfpe_pkg::DIVD_W-1:0] prod;
  logic [wsfpe_pkg::DIVD_W-1:0] div_dvd;
  logic [wsfpe_pkg::DIVS_W-1:0] div_dvs;
  logic [wsfpe_pkg::DIVD_W-1:0] div_quo;
  logic                         div_busy;
  logic                         div_done;
  logic [wsfpe_pkg::CH_W-1:0]   white_q;
  logic [wsfpe_pkg::CH_W-1:0]   mix_red;
  logic [wsfpe_pkg::CH_W-1:0]   mix_green;
  logic [wsfpe_pkg::CH_W-1:0]   mix_blue;

  // pixel memory
  logic [wsfpe_pkg::WORD_W-1:0]    mem [wsfpe_pkg::LED_COUNT];
  logic [wsfpe_pkg::LED_COUNT-1:0] valid_r;
  logic [wsfpe_pkg::WORD_W-1:0]    rd_word_r;
  logic                            rd_vld_r;
  logic [wsfpe_pkg::WORD_W-1:0]    wr_word;

  // slot position
  logic [wsfpe_pkg::SLOT_W-1:0] slot_r;
  logic [wsfpe_pkg::BIT_W-1:0]  bit_r;
  logic [wsfpe_pkg::LED_AW-1:0] led_r;
  logic                         in_data;
  logic                         frame_end;
  logic [wsfpe_pkg::DUTY_W-1:0] duty_sel;

  // output register
  logic                         out_valid_r;
  logic [wsfpe_pkg::DUTY_W-1:0] out_duty_r;
  logic                         out_last_r;
  logic                         out_free;

  // floor(x / 7) by reciprocal multiply
  function automatic logic [wsfpe_pkg::CH_W-1:0] div7(
    input logic [wsfpe_pkg::MIX_NW-1:0] x
  );
    logic [wsfpe_pkg::MIX_PW-1:0] p;
    p = wsfpe_pkg::MIX_PW'(x) * wsfpe_pkg::MIX_PW'(wsfpe_pkg::MIX_RECIP);
    return p[wsfpe_pkg::MIX_SHIFT +: wsfpe_pkg::CH_W];
  endfunction

  function automatic logic [wsfpe_pkg::MIX_NW-1:0] times6(
    input logic [wsfpe_pkg::CH_W-1:0] c
  );
    return (wsfpe_pkg::MIX_NW'(c) << 2) + (wsfpe_pkg::MIX_NW'(c) << 1);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r   <= wsfpe_pkg::BRIGHT_RST;
      one_r      <= wsfpe_pkg::ONE_RST;
      zero_r     <= wsfpe_pkg::ZERO_RST;
      rst_duty_r <= wsfpe_pkg::RESET_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        wsfpe_pkg::REG_BRIGHT: bright_r   <= cfg_wdata[wsfpe_pkg::CH_W-1:0];
        wsfpe_pkg::REG_ONE:    one_r      <= cfg_wdata[wsfpe_pkg::DUTY_W-1:0];
        wsfpe_pkg::REG_ZERO:   zero_r     <= cfg_wdata[wsfpe_pkg::DUTY_W-1:0];
        wsfpe_pkg::REG_RESET:  rst_duty_r <= cfg_wdata[wsfpe_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // largest channel
  always_comb begin
    max_c = red_r;
    if (green_r > max_c) max_c = green_r;
    if (blue_r > max_c) max_c = blue_r;
  end

  always_comb begin
    case (cmd.op)
      wsfpe_pkg::OP_SC_G: sel_c = green_r;
      wsfpe_pkg::OP_SC_B: sel_c = blue_r;
      default:            sel_c = red_r;
    endcase
  end

  assign prod = wsfpe_pkg::DIVD_W'(sel_c) * wsfpe_pkg::DIVD_W'(bright_r);

  // white mixing: floor(6c/7) + floor(w/7), at most 254
  assign white_q   = div7(wsfpe_pkg::MIX_NW'(white_r));
  assign mix_red   = div7(times6(red_r)) + white_q;
  assign mix_green = div7(times6(green_r)) + white_q;
  assign mix_blue  = div7(times6(blue_r)) + white_q;

  // scaling: channel times brightness over largest channel
  assign div_dvd = prod;
  assign div_dvs = {1'b0, max_c};

  wsfpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (div_quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r  <= wsfpe_pkg::LED_AW'(in_pixel_index % wsfpe_pkg::LED_COUNT);
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      white_r <= in_white;
    end else if (cmd.mix) begin
      red_r   <= mix_red;
      green_r <= mix_green;
      blue_r  <= mix_blue;
    end else if (cmd.capture) begin
      case (cmd.op)
        wsfpe_pkg::OP_SC_R:  word_r[15:8] <= div_quo[wsfpe_pkg::CH_W-1:0];
        wsfpe_pkg::OP_SC_G:  word_r[23:16] <= div_quo[wsfpe_pkg::CH_W-1:0];
        wsfpe_pkg::OP_SC_B:  word_r[7:0] <= div_quo[wsfpe_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // black colour stores zero, scaling is skipped
  assign wr_word = (max_c == '0) ? '0 : word_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr_r] <= wr_word;
    end
    if (cmd.mem_rd) begin
      rd_word_r <= mem[led_r];
      rd_vld_r  <= valid_r[led_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.mem_wr) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  // slot decode
  assign in_data   = (slot_r >= DATA_START) && (slot_r < EXTRA_SLOT);
  assign frame_end = (slot_r == LAST_SLOT);

  always_comb begin
    if (in_data) begin
      duty_sel = (rd_vld_r && rd_word_r[bit_r]) ? one_r : zero_r;
    end else if (slot_r == EXTRA_SLOT) begin
      duty_sel = zero_r;
    end else begin
      duty_sel = rst_duty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      bit_r  <= MSB_BIT;
      led_r  <= '0;
    end else if (cmd.out_load) begin
      if (frame_end) begin
        slot_r <= '0;
        bit_r  <= MSB_BIT;
        led_r  <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
        if (in_data) begin
          if (bit_r == '0) begin
            bit_r <= MSB_BIT;
            led_r <= (led_r == LAST_LED) ? '0 : led_r + 1'b1;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
      end
    end
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_duty_r <= duty_sel;
      out_last_r <= frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign out_last  = out_last_r;

  assign sts.div_done = div_done;
  assign sts.m_zero   = (max_c == '0);
  assign sts.out_free = out_free;

  // assertions
  a_wr_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> !div_busy)
    else $error("pixel write while divider busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output overwritten before taken");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && frame_end) |=> (slot_r == '0 && bit_r == MSB_BIT && led_r == '0))
    else $error("slot counters not rewound at frame end");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> $past(div_busy))
    else $error("divider done without run");

endmodule

FILE: rtl/core/wsfpe_ctrl.sv
// ----------------------------------------------------------------------------
// wsfpe_ctrl
// controller: item decode, mixing, divider sequencing, tick read and output
// ----------------------------------------------------------------------------
module wsfpe_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic [wsfpe_pkg::FUNC_W-1:0]  in_func,
  output logic                          in_tready,
  output wsfpe_pkg::cmd_t               cmd,
  input  wsfpe_pkg::sts_t               sts
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_WAIT     = 3'd2;
  localparam logic [2:0] S_WRITE    = 3'd3;
  localparam logic [2:0] S_TICK_RD  = 3'd4;
  localparam logic [2:0] S_TICK_OUT = 3'd5;
  localparam logic [2:0] S_MIX      = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [wsfpe_pkg::OP_W-1:0] op_r, op_nxt;
  logic                       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (in_func)
            wsfpe_pkg::FUNC_SET_RGB: begin
              op_nxt    = wsfpe_pkg::OP_SC_R;
              state_nxt = S_START;
            end
            wsfpe_pkg::FUNC_SET_RGBW: begin
              op_nxt    = wsfpe_pkg::OP_SC_R;
              state_nxt = S_MIX;
            end
            wsfpe_pkg::FUNC_TICK: state_nxt = S_TICK_RD;
            default: cmd.clear = 1'b1;
          endcase
        end
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        if (sts.m_zero) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
          case (op_r)
            wsfpe_pkg::OP_SC_R:  op_nxt = wsfpe_pkg::OP_SC_G;
            wsfpe_pkg::OP_SC_G:  op_nxt = wsfpe_pkg::OP_SC_B;
            default:             state_nxt = S_WRITE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_TICK_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_TICK_OUT;
      end
      S_TICK_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= wsfpe_pkg::OP_SC_R;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

FILE: rtl/core/ws2812_frame_pwm_encoder.sv
// ----------------------------------------------------------------------------
// ws2812_frame_pwm_encoder
// ws2812 frame encoder: scaled pixel store and per-slot pwm compare output
// ----------------------------------------------------------------------------
// tick: pixel memory read, then out register load, after which the next item is
// taken while the out register is free, else the tick waits until it is taken
// set rgb: red, green and blue scale divisions, then the write, then the next item
// set rgbw: a white mixing step comes first; a black colour skips scaling
// clear: done at accept; the bit-serial divider sets the pixel write time
// synchronous active-low reset: registers to defaults, slot position zero,
// pixel valid bits cleared at once so every pixel reads as zero, no sweep
// ----------------------------------------------------------------------------
module ws2812_frame_pwm_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_index, red, green, blue, white
  input  logic [1:0]  in_tuser,   // func
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // duty, zero pad
  output logic        out_tlast,  // frame_end
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  wsfpe_pkg::cmd_t               cmd;
  wsfpe_pkg::sts_t               sts;
  logic [wsfpe_pkg::DUTY_W-1:0]  duty;

  // controller sequences decode, mixing, divider runs, tick read and output load
  wsfpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath holds registers, pixel memory, divider and slot counters
  wsfpe_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel_index (in_tdata[7:0]),
    .in_red         (in_tdata[15:8]),
    .in_green       (in_tdata[23:16]),
    .in_blue        (in_tdata[31:24]),
    .in_white       (in_tdata[39:32]),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_duty       (duty),
    .out_last       (out_tlast)
  );

  // duty in the low bits, rest of the byte pair zero
  assign out_tdata = {6'd0, duty};

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ws2812 frame encoder: pixel writes and pwm slots
// ----------------------------------------------------------------------------
// items enter on the in_ stream and carry pixel writes, clears and ticks. A
// class keeps its own pixel store, slot counter and register copies. Every
// accepted tick queues the duty and frame_end that the block should return,
// and each accepted result is checked against the oldest entry. A directed
// opening covers the colour corner cases. Random phases under several register
// settings follow, long enough to pass the extra slot and the frame wrap. Both
// sides idle at random, and the receiver stalls once per chosen phase long
// enough to back up the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_REPORTS  = 10;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 370;
  localparam int SETTLE       = 200;      // longer than an rgbw pixel write
  localparam int HOLD_CYCLES  = 300;      // long receiver stall
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct {
    logic [wsfpe_pkg::DUTY_W-1:0] duty;
    logic                         frame_end;
  } slot_exp_t;

  // --------------------------------------------------------------------------
  // predicted frame: pixel store, slot counter and register copies
  // --------------------------------------------------------------------------
  class pwm_frame_tracker;
    logic [wsfpe_pkg::WORD_W-1:0] grb [wsfpe_pkg::LED_COUNT];
    int unsigned                  slot;
    logic [wsfpe_pkg::CH_W-1:0]   bright;
    logic [wsfpe_pkg::DUTY_W-1:0] one_d, zero_d, rst_d;
    slot_exp_t                    slot_queue [$];
    int                           errors;

    function new();
      foreach (grb[i]) grb[i] = '0;
      slot   = 0;
      bright = wsfpe_pkg::BRIGHT_RST;
      one_d  = wsfpe_pkg::ONE_RST;
      zero_d = wsfpe_pkg::ZERO_RST;
      rst_d  = wsfpe_pkg::RESET_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [wsfpe_pkg::CFG_AW-1:0] idx,
                            logic [wsfpe_pkg::CFG_DW-1:0] v);
      case (idx)
        wsfpe_pkg::REG_BRIGHT: bright = v[wsfpe_pkg::CH_W-1:0];
        wsfpe_pkg::REG_ONE:    one_d  = v;
        wsfpe_pkg::REG_ZERO:   zero_d = v;
        wsfpe_pkg::REG_RESET:  rst_d  = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return slot_queue.size();
    endfunction

    // largest channel lands on brightness, black stays black
    function void store_color(int unsigned idx, int unsigned r, int unsigned g,
                              int unsigned b);
      int unsigned m;
      logic [wsfpe_pkg::WORD_W-1:0] w;
      m = r;
      w = '0;
      if (g > m) m = g;
      if (b > m) m = b;
      if (m != 0) begin
        w[23:16] = 8'((g * bright) / m);
        w[15:8]  = 8'((r * bright) / m);
        w[7:0]   = 8'((b * bright) / m);
      end
      grb[idx % wsfpe_pkg::LED_COUNT] = w;
    endfunction

    function int unsigned mix(int unsigned c, int unsigned w);
      return (6 * c) / 7 + w / 7;
    endfunction

    function void take_item(logic [wsfpe_pkg::FUNC_W-1:0] f, logic [39:0] d);
      int unsigned idx, r, g, b, w, q, bitn;
      slot_exp_t e;
      idx = 32'(d[7:0]);
      r   = 32'(d[15:8]);
      g   = 32'(d[23:16]);
      b   = 32'(d[31:24]);
      w   = 32'(d[39:32]);
      case (f)
        wsfpe_pkg::FUNC_SET_RGB:  store_color(idx, r, g, b);
        wsfpe_pkg::FUNC_SET_RGBW: store_color(idx, mix(r, w), mix(g, w), mix(b, w));
        wsfpe_pkg::FUNC_CLEAR:    foreach (grb[i]) grb[i] = '0;
        default: begin
          if (slot < wsfpe_pkg::LEAD_RESET_SLOTS) begin
            e.duty = rst_d;
          end else if (slot < wsfpe_pkg::LEAD_RESET_SLOTS + wsfpe_pkg::DATA_SLOTS) begin
            q    = slot - wsfpe_pkg::LEAD_RESET_SLOTS;
            bitn = 23 - (q % wsfpe_pkg::BITS_PER_LED);
            e.duty = grb[q / wsfpe_pkg::BITS_PER_LED][bitn] ? one_d : zero_d;
          end else if (slot == wsfpe_pkg::LEAD_RESET_SLOTS + wsfpe_pkg::DATA_SLOTS) begin
            e.duty = zero_d;
          end else begin
            e.duty = rst_d;
          end
          e.frame_end = (slot + 1 >= wsfpe_pkg::FRAME_SLOTS);
          slot = e.frame_end ? 0 : slot + 1;
          slot_queue.push_back(e);
        end
      endcase
    endfunction

    function void match_slot(logic [wsfpe_pkg::DUTY_W-1:0] duty, logic frame_end);
      slot_exp_t e;
      if (slot_queue.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: duty %0d frame_end %0b", duty, frame_end);
        return;
      end
      e = slot_queue.pop_front();
      if (duty !== e.duty || frame_end !== e.frame_end) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("slot mismatch: duty exp %0d got %0d, frame_end exp %0b got %0b",
                   e.duty, duty, e.frame_end, frame_end);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // pixel_index, red, green, blue, white
  logic [1:0]  in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // duty, zero pad
  logic        out_tlast;  // frame_end
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [9:0]  cfg_wdata;

  ws2812_frame_pwm_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pwm_frame_tracker board;
  int  cycles;
  bit  hold_off_req;
  int  send_run;
  int  recv_run;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.match_slot(out_tdata[wsfpe_pkg::DUTY_W-1:0], out_tlast);
  end

  // idle gap per item, with occasional runs of back-to-back items
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [39:0] pack_px(int unsigned idx, int unsigned r,
                                          int unsigned g, int unsigned b,
                                          int unsigned w);
    return {w[7:0], b[7:0], g[7:0], r[7:0], idx[7:0]};
  endfunction

  // one item on the input stream; called and returns at a falling edge
  task automatic offer_item(input logic [wsfpe_pkg::FUNC_W-1:0] f,
                            input logic [39:0] d);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_item(f, d);
    @(negedge clk);
  endtask

  // all four registers, back to back, only while the block is idle
  task automatic load_settings(input logic [9:0] br, input logic [9:0] one,
                               input logic [9:0] zero, input logic [9:0] rst);
    logic [9:0] vals [4];
    vals[0] = br;
    vals[1] = one;
    vals[2] = zero;
    vals[3] = rst;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.write_reg(i[1:0], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // all results in, then room for a pixel write still in flight
  task automatic wait_idle();
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // receiver: random stalls, one long stall on request
  initial begin
    int gap;
    out_tready = 1'b0;
    recv_run   = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = draw_gap(recv_run);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [9:0]  br_set [PHASES];
    logic [9:0]  one_set [PHASES];
    logic [9:0]  zero_set [PHASES];
    logic [9:0]  rst_set [PHASES];
    int unsigned roll;
    int unsigned r, g, b;
    logic [wsfpe_pkg::FUNC_W-1:0] f;

    board        = new();
    cycles       = 0;
    hold_off_req = 1'b0;
    send_run     = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = wsfpe_pkg::FUNC_TICK;
    cfg_we       = 1'b0;
    cfg_addr     = wsfpe_pkg::REG_BRIGHT;
    cfg_wdata    = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening, reset register values
    offer_item(wsfpe_pkg::FUNC_TICK,    '0);                         // lead reset slot
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(0, 255, 0, 0, 0));   // single full channel
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(64, 1, 2, 3, 0));    // index wraps onto 0
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(1, 0, 0, 0, 255));   // black stays zero
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(255, 255, 255, 255, 0));
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(2, 0, 0, 1, 0));     // tiny value scales up
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(3, 17, 200, 3, 0));
    offer_item(wsfpe_pkg::FUNC_SET_RGBW, pack_px(4, 255, 255, 255, 255)); // mix tops out
    offer_item(wsfpe_pkg::FUNC_SET_RGBW, pack_px(5, 0, 0, 0, 0));    // black after mix
    offer_item(wsfpe_pkg::FUNC_SET_RGBW, pack_px(6, 0, 0, 0, 6));    // white below one step
    offer_item(wsfpe_pkg::FUNC_SET_RGBW, pack_px(7, 0, 0, 0, 7));    // white of one step
    offer_item(wsfpe_pkg::FUNC_SET_RGBW, pack_px(8, 200, 10, 90, 130));
    offer_item(wsfpe_pkg::FUNC_TICK,    40'hff_ffff_ffff);
    offer_item(wsfpe_pkg::FUNC_CLEAR,   '0);
    offer_item(wsfpe_pkg::FUNC_TICK,    '0);
    offer_item(wsfpe_pkg::FUNC_SET_RGB, pack_px(9, 0, 255, 128, 0));
    offer_item(wsfpe_pkg::FUNC_TICK,    '0);
    in_tvalid <= 1'b0;
    wait_idle();

    // register settings per phase: defaults, both extremes, then random
    br_set[0] = 10'd255; one_set[0] = 10'd60;   zero_set[0] = 10'd30;   rst_set[0] = 10'd0;
    br_set[1] = 10'd0;   one_set[1] = 10'd1023; zero_set[1] = 10'd0;    rst_set[1] = 10'd1023;
    br_set[2] = 10'd1;   one_set[2] = 10'd0;    zero_set[2] = 10'd1023; rst_set[2] = 10'd0;
    for (int p = 3; p < PHASES; p++) begin
      br_set[p]   = 10'($urandom_range(0, 255));
      one_set[p]  = 10'($urandom_range(0, 1023));
      zero_set[p] = 10'($urandom_range(0, 1023));
      rst_set[p]  = 10'($urandom_range(0, 1023));
    end

    for (int p = 0; p < PHASES; p++) begin
      load_settings(br_set[p], one_set[p], zero_set[p], rst_set[p]);
      @(negedge clk);
      // long receiver stall at the start of some phases to back up the block
      if (p == 1 || p == 3) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 127);
        if (roll == 0)       f = wsfpe_pkg::FUNC_CLEAR;
        else if (roll < 5)   f = wsfpe_pkg::FUNC_SET_RGB;
        else if (roll < 9)   f = wsfpe_pkg::FUNC_SET_RGBW;
        else                 f = wsfpe_pkg::FUNC_TICK;
        // colours: mostly full range, some black, some one channel only
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        case ($urandom_range(0, 7))
          0: begin r = 0; g = 0; b = 0; end
          1: begin g = 0; b = 0; end
          2: begin r = 0; b = 0; end
          default: ;
        endcase
        offer_item(f, pack_px($urandom_range(0, 255), r, g, b, $urandom_range(0, 255)));
      end
      in_tvalid <= 1'b0;
      wait_idle();
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
